// ===== rtl/core/grce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad report change events: shared package
// Sizes, reset values, event codes and the queue entry type.
// ----------------------------------------------------------------------------
package grce_pkg;

    // Report layout.
    localparam int AXIS_TOTAL   = 5;
    localparam int AXIS_BYTES   = 5;
    localparam int BUTTON_TOTAL = 12;
    localparam int BUTTON_COUNT = 12;

    // Reset values of the stored report.
    localparam logic [7:0]  AXIS_RESET   = 8'h0D;
    localparam logic [7:0]  HAT_RESET    = 8'hDE;
    localparam logic [11:0] BUTTON_RESET = 12'h000;

    // Only the first BUTTON_COUNT buttons produce events.
    localparam logic [BUTTON_TOTAL-1:0] BUTTON_MASK =
        BUTTON_TOTAL'((13'd1 << BUTTON_COUNT) - 13'd1);

    // Event kinds.
    localparam logic [1:0] KIND_AXES     = 2'd0;
    localparam logic [1:0] KIND_HAT      = 2'd1;
    localparam logic [1:0] KIND_BTN_DOWN = 2'd2;
    localparam logic [1:0] KIND_BTN_UP   = 2'd3;

    // Queue between the classifier and the event sequencer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified report: everything the sequencer needs.
    typedef struct packed {
        logic [AXIS_TOTAL-1:0][7:0]  axes;
        logic [3:0]                  hat;
        logic                        axis_chg;
        logic                        hat_chg;
        logic [BUTTON_TOTAL-1:0]     btn_diff;
        logic [BUTTON_TOTAL-1:0]     buttons;
    } grce_entry_t;

endpackage

// ===== rtl/core/grce_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad report change events: report classifier
// Accepts reports, compares them with the stored report, updates the stored
// report and queues a description of every change.
// ----------------------------------------------------------------------------
module grce_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           axis_x,
    input  logic [7:0]           axis_y,
    input  logic [7:0]           axis_z1,
    input  logic [7:0]           axis_z2,
    input  logic [7:0]           axis_rz,
    input  logic [7:0]           hat_and_low_buttons,
    input  logic [7:0]           high_buttons,
    output logic                 push_valid,
    output grce_pkg::grce_entry_t push_entry,
    input  logic                 push_full
);
    import grce_pkg::*;

    logic [AXIS_BYTES-1:0][7:0]   prev_axes_reg, prev_axes_next;
    logic [7:0]                   prev_hat_reg, prev_hat_next;
    logic [BUTTON_TOTAL-1:0]      prev_buttons_reg, prev_buttons_next;

    logic [AXIS_TOTAL-1:0][7:0]   axes_in;
    logic [3:0]                   hat_in;
    logic [BUTTON_TOTAL-1:0]      buttons_in;
    logic [BUTTON_TOTAL-1:0]      diff;
    logic                         axis_chg;
    logic                         hat_chg;
    logic                         accept;

    // Unpack the report bytes.
    assign axes_in    = {axis_rz, axis_z2, axis_z1, axis_y, axis_x};
    assign hat_in     = hat_and_low_buttons[3:0];
    assign buttons_in = {high_buttons, hat_and_low_buttons[7:4]};

    // A request is taken whenever the queue has room.
    assign in_stall = push_full;
    assign accept   = in_valid && !push_full;

    // Compare with the stored report.
    always_comb
    begin
        axis_chg = 1'b0;
        for (int i = 0; i < AXIS_BYTES; i++)
        begin
            if (axes_in[i] != prev_axes_reg[i])
            begin
                axis_chg = 1'b1;
            end
        end
        hat_chg = ({4'h0, hat_in} != prev_hat_reg);
        diff    = (buttons_in ^ prev_buttons_reg) & BUTTON_MASK;
    end

    // Build the queue entry; reports without a change are dropped here.
    always_comb
    begin
        push_entry.axes     = axes_in;
        push_entry.hat      = hat_in;
        push_entry.axis_chg = axis_chg;
        push_entry.hat_chg  = hat_chg;
        push_entry.btn_diff = diff;
        push_entry.buttons  = buttons_in;
        push_valid          = accept && (axis_chg || hat_chg || (diff != '0));
    end

    // Update the stored report on every accepted request.
    always_comb
    begin
        prev_axes_next    = prev_axes_reg;
        prev_hat_next     = prev_hat_reg;
        prev_buttons_next = prev_buttons_reg;
        if (accept)
        begin
            if (axis_chg)
            begin
                for (int i = 0; i < AXIS_BYTES; i++)
                begin
                    prev_axes_next[i] = axes_in[i];
                end
            end
            if (hat_chg)
            begin
                prev_hat_next = {4'h0, hat_in};
            end
            prev_buttons_next = buttons_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXIS_BYTES; i++)
            begin
                prev_axes_reg[i] <= AXIS_RESET;
            end
            prev_hat_reg     <= HAT_RESET;
            prev_buttons_reg <= BUTTON_RESET;
        end
        else
        begin
            prev_axes_reg    <= prev_axes_next;
            prev_hat_reg     <= prev_hat_next;
            prev_buttons_reg <= prev_buttons_next;
        end
    end

endmodule

// ===== rtl/core/grce_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad report change events: entry queue
// Small first-in first-out buffer between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module grce_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    input  grce_pkg::grce_entry_t push_entry,
    output logic                  push_full,
    input  logic                  pop,
    output logic                  pop_valid,
    output grce_pkg::grce_entry_t pop_entry
);
    import grce_pkg::*;

    grce_entry_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign push_full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    assign do_push = push_valid && !push_full;
    assign do_pop  = pop && pop_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/core/grce_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad report change events: event sequencer
// Walks the pending changes of one report, one event per cycle while the output is not
// stalled, in the order axes, hat, buttons by ascending number, into a registered output.
// ----------------------------------------------------------------------------
module grce_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    input  grce_pkg::grce_entry_t pop_entry,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            event_kind,
    output logic [7:0]            out_x,
    output logic [7:0]            out_y,
    output logic [7:0]            out_z1,
    output logic [7:0]            out_z2,
    output logic [7:0]            out_rz,
    output logic [3:0]            hat_value,
    output logic [3:0]            button_id,
    output logic                  last
);
    import grce_pkg::*;

    localparam int BIDX_W = $clog2(BUTTON_TOTAL);

    // Report being worked on.
    logic                        cur_valid_reg, cur_valid_next;
    grce_entry_t                 cur_reg, cur_next;

    // Output register.
    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  kind_reg, kind_next;
    logic [AXIS_TOTAL-1:0][7:0]  axes_reg, axes_next;
    logic [3:0]                  hat_reg, hat_next;
    logic [3:0]                  id_reg, id_next;
    logic                        last_reg, last_next;

    logic                        load_ok;
    logic                        emit;
    logic [BIDX_W-1:0]           btn_idx;
    logic                        is_last;
    grce_entry_t                 cur_after;

    assign load_ok = !out_valid_reg || !out_stall;
    assign emit    = cur_valid_reg && load_ok;

    // Lowest pending button. An entry always holds at least one change, so
    // some bit is set whenever neither axes nor hat is pending.
    always_comb
    begin
        btn_idx = '0;
        for (int i = BUTTON_TOTAL - 1; i >= 0; i--)
        begin
            if (cur_reg.btn_diff[i])
            begin
                btn_idx = BIDX_W'(i);
            end
        end
    end

    // Choose the next event and clear it from the pending set.
    always_comb
    begin
        cur_after = cur_reg;
        kind_next = kind_reg;
        axes_next = axes_reg;
        hat_next  = hat_reg;
        id_next   = id_reg;
        if (cur_reg.axis_chg)
        begin
            cur_after.axis_chg = 1'b0;
            kind_next = KIND_AXES;
            axes_next = cur_reg.axes;
            hat_next  = 4'h0;
            id_next   = 4'h0;
        end
        else if (cur_reg.hat_chg)
        begin
            cur_after.hat_chg = 1'b0;
            kind_next = KIND_HAT;
            axes_next = '0;
            hat_next  = cur_reg.hat;
            id_next   = 4'h0;
        end
        else
        begin
            cur_after.btn_diff[btn_idx] = 1'b0;
            kind_next = cur_reg.buttons[btn_idx] ? KIND_BTN_DOWN : KIND_BTN_UP;
            axes_next = '0;
            hat_next  = 4'h0;
            id_next   = 4'(btn_idx) + 4'd1;
        end
        is_last = !cur_after.axis_chg && !cur_after.hat_chg && (cur_after.btn_diff == '0);
        if (!emit)
        begin
            kind_next = kind_reg;
            axes_next = axes_reg;
            hat_next  = hat_reg;
            id_next   = id_reg;
        end
    end

    // Pull the next report when idle or when the current one finishes.
    assign pop = pop_valid && (!cur_valid_reg || (emit && is_last));

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (emit)
        begin
            cur_next = cur_after;
            if (is_last)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (pop)
        begin
            cur_next       = pop_entry;
            cur_valid_next = 1'b1;
        end
    end

    // Output valid and last flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        last_next      = last_reg;
        if (load_ok)
        begin
            out_valid_next = emit;
        end
        if (emit)
        begin
            last_next = is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        kind_reg <= kind_next;
        axes_reg <= axes_next;
        hat_reg  <= hat_next;
        id_reg   <= id_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_reg;
    assign out_x      = axes_reg[0];
    assign out_y      = axes_reg[1];
    assign out_z1     = axes_reg[2];
    assign out_z2     = axes_reg[3];
    assign out_rz     = axes_reg[4];
    assign hat_value  = hat_reg;
    assign button_id  = id_reg;
    assign last       = last_reg;

endmodule

// ===== rtl/core/gamepad_report_change_events.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad report change events: top level
// Turns seven-byte joystick reports into axis, hat and button events.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) takes one report per request. The
// block compares it with the previous report and emits, on the output channel
// (out_valid / out_stall), an axis event if any axis byte changed, a hat event
// if the hat changed, then one down or up event per changed button in
// ascending order. The final event of a report has last set; a report that
// changes nothing gives no event. Fields not used by an event kind are zero.
// An accepted report passes the queue, the current-report register and the
// output register before its first event is presented. The event sequencer
// emits one event per cycle while the output is not stalled; a report gives
// at most fourteen events. The classifier takes one report per cycle while
// the four-entry queue has room; in_stall rises only when that queue is full.
// When the receiver stalls, the registered output holds its event, the
// sequencer waits and the queue fills behind it.
// Reset clears the queue and output and restores the stored report: axes
// 0x0D, a hat value no report can match, and all buttons released.
// ----------------------------------------------------------------------------
module gamepad_report_change_events (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] axis_x,
    input  logic [7:0] axis_y,
    input  logic [7:0] axis_z1,
    input  logic [7:0] axis_z2,
    input  logic [7:0] axis_rz,
    input  logic [7:0] hat_and_low_buttons,
    input  logic [7:0] high_buttons,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] event_kind,
    output logic [7:0] out_x,
    output logic [7:0] out_y,
    output logic [7:0] out_z1,
    output logic [7:0] out_z2,
    output logic [7:0] out_rz,
    output logic [3:0] hat_value,
    output logic [3:0] button_id,
    output logic       last
);
    import grce_pkg::*;

    logic        push_valid;
    grce_entry_t push_entry;
    logic        push_full;
    logic        pop;
    logic        pop_valid;
    grce_entry_t pop_entry;

    // Classifier.
    grce_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .axis_x              (axis_x),
        .axis_y              (axis_y),
        .axis_z1             (axis_z1),
        .axis_z2             (axis_z2),
        .axis_rz             (axis_rz),
        .hat_and_low_buttons (hat_and_low_buttons),
        .high_buttons        (high_buttons),
        .push_valid          (push_valid),
        .push_entry          (push_entry),
        .push_full           (push_full)
    );

    // Queue between the two halves.
    grce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_full  (push_full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry)
    );

    // Event sequencer.
    grce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_kind (event_kind),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z1     (out_z1),
        .out_z2     (out_z2),
        .out_rz     (out_rz),
        .hat_value  (hat_value),
        .button_id  (button_id),
        .last       (last)
    );

endmodule
